// ===== rtl/tempo_clock_with_meter_divisions_core_defines.svh =====
// Assertion macros shared by the tempo clock RTL.
// Both expect clk and rst_n in scope; checks are off while reset is held.
`ifndef TEMPO_CLOCK_WITH_METER_DIVISIONS_CORE_DEFINES_SVH
`define TEMPO_CLOCK_WITH_METER_DIVISIONS_CORE_DEFINES_SVH

// Condition holds on every clock edge.
`define TCMD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define TCMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tcmd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcmd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMPO_BPM         = 2'd0,
    CFG_METER_TOP         = 2'd1,
    CFG_METER_BOTTOM_CODE = 2'd2,
    CFG_SAMPLE_RATE_HZ    = 2'd3
  } cfg_idx_t;

  // Denominator codes: denominator is 2^(code+1)
  typedef enum logic [1:0] {
    METER_HALF      = 2'd0,
    METER_QUARTER   = 2'd1,
    METER_EIGHTH    = 2'd2,
    METER_SIXTEENTH = 2'd3
  } meter_code_t;

  typedef enum logic [1:0] {
    EDGE_UNKNOWN = 2'd0,
    EDGE_LOW     = 2'd1,
    EDGE_HIGH    = 2'd2
  } edge_st_t;

  localparam int unsigned CFG_DATA_W   = 18;
  localparam int unsigned TDATA_W      = 8;
  localparam int unsigned MOD_W        = 24;   // 60 * max sample rate
  localparam logic [1:0]  EIGHTH_LIMIT = 2'd2;
  localparam logic [2:0]  MULT_SIMPLE  = 3'd4;
  localparam logic [2:0]  MULT_COMPOUND = 3'd6;
  localparam logic [5:0]  BAR_DEFAULT  = 6'd16;

  localparam logic signed [1:0] LEVEL_HIGH = 2'sb01;
  localparam logic signed [1:0] LEVEL_LOW  = 2'sb11;
  localparam logic signed [1:0] LEVEL_OFF  = 2'sb00;

  typedef struct packed {
    logic [7:0]  tempo_bpm;
    logic [3:0]  meter_top;
    logic [1:0]  meter_bottom_code;
    logic [17:0] sample_rate_hz;
  } cfg_t;

  typedef struct packed {
    logic signed [1:0] sixteenth_level;
    logic              eighth_gate;
    logic              beat_gate;
    logic              bar_gate;
    logic              run_lamp;
    logic              reset_lamp;
  } res_t;

  typedef struct packed {
    edge_st_t st;
    logic     fire;
  } edge_res_t;

  // Edge detector: from unknown the first level only sets the state.
  function automatic edge_res_t edge_step(edge_st_t st, logic level_high);
    edge_res_t r;
    r.st   = st;
    r.fire = 1'b0;
    case (st)
      EDGE_LOW: begin
        if (level_high) begin
          r.st   = EDGE_HIGH;
          r.fire = 1'b1;
        end
      end
      EDGE_HIGH: begin
        if (!level_high) r.st = EDGE_LOW;
      end
      default: begin
        r.st = level_high ? EDGE_HIGH : EDGE_LOW;
      end
    endcase
    return r;
  endfunction

  // Wrap counter: bump on edge unless past limit, clear at or above limit.
  function automatic logic [5:0] count_step(logic [5:0] cnt, logic [5:0] lim, logic ev);
    logic [6:0] v;
    v = {1'b0, cnt};
    if (ev && (cnt <= lim)) v = v + 7'd1;
    if (v >= {1'b0, lim}) v = 7'd0;
    return v[5:0];
  endfunction

  function automatic logic div_by_3(logic [3:0] v);
    logic r;
    case (v)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tcmd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcmd_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire tcmd_pkg::cfg_idx_t             wr_index,
  input  wire logic [tcmd_pkg::CFG_DATA_W-1:0] wr_data,
  output tcmd_pkg::cfg_t                      cfg
);
  import tcmd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tempo_bpm         <= 8'd120;
      cfg_r.meter_top         <= 4'd4;
      cfg_r.meter_bottom_code <= METER_QUARTER;
      cfg_r.sample_rate_hz    <= 18'd44100;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TEMPO_BPM:         cfg_r.tempo_bpm         <= wr_data[7:0];
        CFG_METER_TOP:         cfg_r.meter_top         <= wr_data[3:0];
        CFG_METER_BOTTOM_CODE: cfg_r.meter_bottom_code <= wr_data[1:0];
        CFG_SAMPLE_RATE_HZ:    cfg_r.sample_rate_hz    <= wr_data[17:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/tcmd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "tempo_clock_with_meter_divisions_core_defines.svh"

// Per-tick state update: run toggle, meter decode, phase step, division counters.
module tcmd_core #(
  parameter int unsigned PHASE_BITS = 24
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step_en,
  input  wire logic           run_button,
  input  wire logic           clear_button,
  input  wire tcmd_pkg::cfg_t cfg,
  output tcmd_pkg::res_t      res
);
  import tcmd_pkg::*;

  localparam int unsigned SW = ((PHASE_BITS > MOD_W) ? PHASE_BITS : MOD_W) + 1;
  localparam int unsigned CW = SW + 1;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic                  run_flag_r, run_flag_nxt;
  edge_st_t              run_edge_r, run_edge_nxt;
  edge_st_t              clk_edge_r, clk_edge_nxt;
  logic [1:0]            eighth_count_r, eighth_count_nxt;
  logic [2:0]            beat_count_r, beat_count_nxt;
  logic [5:0]            bar_count_r, bar_count_nxt;
  logic [2:0]            beat_limit_r, beat_limit_nxt;
  logic [5:0]            bar_limit_r, bar_limit_nxt;
  logic [2:0]            rate_mult_r, rate_mult_nxt;

  edge_res_t   run_e, clk_e;
  logic [17:0] rate;
  logic [23:0] modulus;
  logic [22:0] half;
  logic [10:0] delta_raw, delta;
  logic [SW-1:0] sum, sub1, sub2;
  logic        high;
  logic [1:0]  eighth_base;
  logic [2:0]  beat_base;
  logic [5:0]  bar_base;

  function automatic logic [PHASE_BITS-1:0] phase_nxt_w(logic [SW-1:0] v);
    return v[PHASE_BITS-1:0];
  endfunction

  always_comb begin
    run_e        = edge_step(run_edge_r, run_button);
    run_edge_nxt = run_e.st;
    run_flag_nxt = run_flag_r ^ run_e.fire;

    eighth_base = clear_button ? 2'd0 : eighth_count_r;
    beat_base   = clear_button ? 3'd0 : beat_count_r;
    bar_base    = clear_button ? 6'd0 : bar_count_r;

    // Meter decode; unsupported combinations keep the old limits
    rate_mult_nxt  = rate_mult_r;
    beat_limit_nxt = beat_limit_r;
    bar_limit_nxt  = bar_limit_r;
    case (meter_code_t'(cfg.meter_bottom_code))
      METER_HALF: begin
        if (cfg.meter_top == 4'd2) begin
          rate_mult_nxt  = MULT_SIMPLE;
          beat_limit_nxt = MULT_SIMPLE;
          bar_limit_nxt  = BAR_DEFAULT;
        end
      end
      METER_QUARTER: begin
        rate_mult_nxt  = MULT_SIMPLE;
        beat_limit_nxt = MULT_SIMPLE;
        bar_limit_nxt  = {cfg.meter_top, 2'b00};
      end
      METER_EIGHTH: begin
        // (top/3)*6 equals top*2 when top divides by three
        bar_limit_nxt = {1'b0, cfg.meter_top, 1'b0};
        if (div_by_3(cfg.meter_top)) begin
          rate_mult_nxt  = MULT_COMPOUND;
          beat_limit_nxt = MULT_COMPOUND;
        end else begin
          rate_mult_nxt  = MULT_SIMPLE;
          beat_limit_nxt = MULT_SIMPLE;
        end
      end
      default: ;
    endcase

    rate      = (cfg.sample_rate_hz == 18'd0) ? 18'd1 : cfg.sample_rate_hz;
    modulus   = (24'(rate) << 6) - (24'(rate) << 2);
    half      = (23'(rate) << 5) - (23'(rate) << 1);
    delta_raw = (11'(cfg.tempo_bpm) << 2) +
                ((rate_mult_nxt == MULT_COMPOUND) ? (11'(cfg.tempo_bpm) << 1) : 11'd0);
    delta     = (23'(delta_raw) > half) ? half[10:0] : delta_raw;

    sum  = SW'(phase_r) + SW'(delta);
    sub1 = (sum >= SW'(modulus)) ? (sum - SW'(modulus)) : sum;
    sub2 = (sub1 >= SW'(modulus)) ? '0 : sub1;
    high = (CW'({phase_nxt_w(sub2), 1'b0}) < CW'(modulus));

    clk_e = edge_step(clk_edge_r, high);

    res.run_lamp   = run_flag_nxt;
    res.reset_lamp = clear_button;

    if (run_flag_nxt) begin
      phase_nxt        = sub2[PHASE_BITS-1:0];
      clk_edge_nxt     = clk_e.st;
      eighth_count_nxt = 2'(count_step(6'(eighth_base), 6'(EIGHTH_LIMIT), clk_e.fire));
      beat_count_nxt   = 3'(count_step(6'(beat_base), 6'(beat_limit_nxt), clk_e.fire));
      bar_count_nxt    = count_step(bar_base, bar_limit_nxt, clk_e.fire);
      res.sixteenth_level = high ? LEVEL_HIGH : LEVEL_LOW;
      res.eighth_gate  = (eighth_count_nxt == 2'd0);
      res.beat_gate    = (beat_count_nxt == 3'd0);
      res.bar_gate     = (bar_count_nxt == 6'd0);
    end else begin
      // Stopped: phase, clock edge state and limits hold
      phase_nxt        = phase_r;
      clk_edge_nxt     = clk_edge_r;
      rate_mult_nxt    = rate_mult_r;
      beat_limit_nxt   = beat_limit_r;
      bar_limit_nxt    = bar_limit_r;
      eighth_count_nxt = 2'd0;
      beat_count_nxt   = 3'd0;
      bar_count_nxt    = 6'd0;
      res.sixteenth_level = LEVEL_OFF;
      res.eighth_gate  = 1'b0;
      res.beat_gate    = 1'b0;
      res.bar_gate     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= '0;
      run_flag_r     <= 1'b1;
      run_edge_r     <= EDGE_UNKNOWN;
      clk_edge_r     <= EDGE_UNKNOWN;
      eighth_count_r <= 2'd0;
      beat_count_r   <= 3'd0;
      bar_count_r    <= 6'd0;
      beat_limit_r   <= MULT_SIMPLE;
      bar_limit_r    <= BAR_DEFAULT;
      rate_mult_r    <= MULT_SIMPLE;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      run_flag_r     <= run_flag_nxt;
      run_edge_r     <= run_edge_nxt;
      clk_edge_r     <= clk_edge_nxt;
      eighth_count_r <= eighth_count_nxt;
      beat_count_r   <= beat_count_nxt;
      bar_count_r    <= bar_count_nxt;
      beat_limit_r   <= beat_limit_nxt;
      bar_limit_r    <= bar_limit_nxt;
      rate_mult_r    <= rate_mult_nxt;
    end
  end

  // Multiplier and beat length are always decoded together
  `TCMD_ASSERT_ALWAYS(a_mult_matches_beat, rate_mult_r == beat_limit_r, "rate multiplier differs from beat limit")
  `TCMD_ASSERT_ALWAYS(a_beat_limit_legal, beat_limit_r == MULT_SIMPLE || beat_limit_r == MULT_COMPOUND, "beat limit not 4 or 6")
  `TCMD_ASSERT_ALWAYS(a_eighth_in_range, eighth_count_r < EIGHTH_LIMIT, "eighth counter past its limit")

endmodule

`default_nettype wire

// ===== rtl/tempo_clock_with_meter_divisions_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "tempo_clock_with_meter_divisions_core_defines.svh"

// Channel | dir | tdata / payload                          | tuser
// --------+-----+------------------------------------------+------
// in_     | in  | [0] run_button, [1] clear_button          | none
// out_    | out | [1:0] sixteenth_level, [2] eighth_gate,   | none
//         |     | [3] beat_gate, [4] bar_gate,              |
//         |     | [5] run_lamp, [6] reset_lamp              |
// cfg_    | in  | cfg_index (register), cfg_data (value)    | none
//
// One request per cycle sustained while out_tready is high; a tick taken passes
// the input register, then the result register, before it reaches out_.
// Each tick's full update (meter decode, phase add and three modulus
// compares, edge detect, counters) runs combinationally between those registers.
// Reset is synchronous on rst_n: running, phase zero, counters zero, 4/4 defaults.
// A stalled result register holds; one more request waits in the input register.
// cfg_ready is always high; writes are meant for idle periods only.
module tempo_clock_with_meter_divisions_core #(
  parameter int unsigned PHASE_BITS = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: [0] run_button, [1] clear_button, [7:2] zero
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  input  wire logic [tcmd_pkg::TDATA_W-1:0]       in_tdata,
  // out_tdata: [1:0] sixteenth_level, [2] eighth_gate, [3] beat_gate,
  //            [4] bar_gate, [5] run_lamp, [6] reset_lamp, [7] zero
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  output      logic [tcmd_pkg::TDATA_W-1:0]       out_tdata,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [tcmd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tcmd_pkg::*;

  // Input register
  logic in_valid_r;
  logic run_btn_r;
  logic rst_btn_r;
  // Result register
  logic out_valid_r;
  res_t out_res_r;

  logic adv;     // tick in input register moves into result register
  cfg_t cfg;
  res_t res;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      run_btn_r <= in_tdata[0];
      rst_btn_r <= in_tdata[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_res_r <= res;
  end

  tcmd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_idx_t'(cfg_index)),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tcmd_core #(
    .PHASE_BITS (PHASE_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (adv),
    .run_button   (run_btn_r),
    .clear_button (rst_btn_r),
    .cfg          (cfg),
    .res          (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0,
                       out_res_r.reset_lamp,
                       out_res_r.run_lamp,
                       out_res_r.bar_gate,
                       out_res_r.beat_gate,
                       out_res_r.eighth_gate,
                       out_res_r.sixteenth_level};

  // A held tick is never dropped while the result side stalls
  `TCMD_ASSERT_NEXT(a_in_hold, in_valid_r && !adv, in_valid_r, "input register lost a waiting tick")
  `TCMD_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r, "advanced tick missing from result register")
  // While stopped the level and all gates are forced low
  `TCMD_ASSERT_ALWAYS(a_stopped_quiet, !out_valid_r || out_res_r.run_lamp || out_tdata[4:0] == 5'd0, "gates active while stopped")

endmodule

`default_nettype wire
